>>> rtl/kapi_pkg.sv
package kapi_pkg;

	localparam int unsigned RING_DEPTH_DEF  = 64;
	localparam int unsigned HANDLE_BITS_DEF = 32;
	localparam logic [23:0] TICKS_RESET     = 24'd90000;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// request kind codes as seen on the input port
	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_ALL    = 3'd1;
	localparam logic [2:0] KIND_SINCE  = 3'd2;
	localparam logic [2:0] KIND_RECENT = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	// configuration register indexes
	localparam logic [7:0] REG_WINDOW = 8'd0;
	localparam logic [7:0] REG_TICKS  = 8'd1;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_ALL,
		OP_SINCE,
		OP_RECENT,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_NONKEY  = 3'd1,
		STAT_DROPPED = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] handle;
		logic [63:0] pts;
		logic [63:0] dts;
		logic        key;
		logic [63:0] since;
		logic [15:0] recent;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  index;
		logic [23:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [63:0] pts;
		logic [63:0] dts;
		logic [31:0] seq;
		logic        key;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic        entry_valid;
		logic [31:0] handle;
		logic [63:0] pts;
		logic [63:0] dts;
		logic [31:0] seq;
		logic        key;
		logic        last;
		logic [6:0]  held;
	} res_t;

endpackage

>>> rtl/kapi_front.sv
module kapi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [31:0]        payload_handle,
	input  logic [63:0]        frame_pts,
	input  logic [63:0]        frame_dts,
	input  logic               is_keyframe,
	input  logic [63:0]        since_pts,
	input  logic [15:0]        recent_seconds,
	output logic               cmd_valid,
	output kapi_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);

	kapi_pkg::cmd_t fifo_q [kapi_pkg::QUEUE_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	kapi_pkg::cmd_t cls;
	logic           push;
	logic           pop;

	// classify the request kind
	always_comb begin
		cls.handle = payload_handle;
		cls.pts    = frame_pts;
		cls.dts    = frame_dts;
		cls.key    = is_keyframe;
		cls.since  = since_pts;
		cls.recent = recent_seconds;
		unique case (kind)
			kapi_pkg::KIND_ADD:    cls.op = kapi_pkg::OP_ADD;
			kapi_pkg::KIND_ALL:    cls.op = kapi_pkg::OP_ALL;
			kapi_pkg::KIND_SINCE:  cls.op = kapi_pkg::OP_SINCE;
			kapi_pkg::KIND_RECENT: cls.op = kapi_pkg::OP_RECENT;
			kapi_pkg::KIND_CLEAR:  cls.op = kapi_pkg::OP_CLEAR;
			default:               cls.op = kapi_pkg::OP_NONE;
		endcase
	end

	assign in_ready  = cnt_q != 2'(kapi_pkg::QUEUE_DEPTH);
	assign push      = in_valid && in_ready;
	assign cmd_valid = cnt_q != 2'd0;
	assign pop       = cmd_valid && cmd_pop;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/kapi_back.sv
module kapi_back #(
	parameter int unsigned RING_DEPTH  = kapi_pkg::RING_DEPTH_DEF,
	parameter int unsigned HANDLE_BITS = kapi_pkg::HANDLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  kapi_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  kapi_pkg::cfg_wr_t cfg,
	output logic              res_valid,
	input  logic              res_ready,
	output kapi_pkg::res_t    res
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN_RD = 8'b0000_0010,
		ST_SCAN_CK = 8'b0000_0100,
		ST_DROP    = 8'b0000_1000,
		ST_RESP    = 8'b0001_0000,
		ST_EMIT_RD = 8'b0010_0000,
		ST_EMIT_LD = 8'b0100_0000,
		ST_SPARE   = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		MD_EVICT,
		MD_SINCE,
		MD_THRESH,
		MD_KEY
	} mode_t;

	logic [HANDLE_BITS-1:0] mem_handle [RING_DEPTH];
	kapi_pkg::entry_t       mem_entry  [RING_DEPTH];
	logic [HANDLE_BITS-1:0] rd_handle_q;
	kapi_pkg::entry_t       rd_entry_q;

	state_t                state_q;
	mode_t                 mode_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [31:0]           seq_q;
	logic [63:0]           newest_q;
	logic [63:0]           since_q;
	logic [39:0]           span_q;
	logic [15:0]           window_q;
	logic [23:0]           ticks_q;
	kapi_pkg::status_t     status_q;
	logic                  out_valid_q;
	kapi_pkg::res_t        res_q;

	logic                  out_free;
	logic                  load_res;
	logic                  full;
	logic                  refuse;
	logic [SUM_W-1:0]      sum_rd;
	logic [SUM_W-1:0]      sum_wr;
	logic [PTR_W-1:0]      rd_slot;
	logic [PTR_W-1:0]      wr_slot;
	logic [PTR_W-1:0]      head_inc;
	logic                  wr_en;
	logic                  rd_en;
	logic [15:0]           mul_a;
	logic [39:0]           mul_p;
	logic [64:0]           diff;
	logic                  in_window;
	logic                  ge_since;
	logic                  is_last;

	assign out_free = !out_valid_q || res_ready;
	assign load_res = ((state_q == ST_RESP) && out_free) || (state_q == ST_EMIT_LD);
	assign full     = count_q == CNT_W'(RING_DEPTH);
	assign refuse   = (count_q == '0) && !cmd.key;

	always_comb begin
		sum_rd  = SUM_W'(head_q) + SUM_W'(idx_q);
		rd_slot = PTR_W'((sum_rd >= SUM_W'(RING_DEPTH)) ? sum_rd - SUM_W'(RING_DEPTH) : sum_rd);
		sum_wr  = SUM_W'(head_q) + (full ? SUM_W'(0) : SUM_W'(count_q));
		wr_slot = PTR_W'((sum_wr >= SUM_W'(RING_DEPTH)) ? sum_wr - SUM_W'(RING_DEPTH) : sum_wr);
		head_inc = (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	end

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign wr_en   = cmd_pop && (cmd.op == kapi_pkg::OP_ADD) && !refuse;
	assign rd_en   = ((state_q == ST_SCAN_RD) && (idx_q != count_q)) ||
	                 ((state_q == ST_EMIT_RD) && out_free);

	// one multiplier serves the eviction window and the recent span
	assign mul_a = (cmd.op == kapi_pkg::OP_ADD) ? window_q : cmd.recent;
	assign mul_p = 40'(mul_a) * 40'(ticks_q);

	// exact newest - pts <= span test
	assign diff      = {newest_q[63], newest_q} - {rd_entry_q.pts[63], rd_entry_q.pts};
	assign in_window = ($signed(rd_entry_q.pts) >= $signed(newest_q)) ||
	                   (diff[63:0] <= {24'd0, span_q});
	assign ge_since  = $signed(rd_entry_q.pts) >= $signed(since_q);
	assign is_last   = idx_q == (count_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_handle[wr_slot] <= HANDLE_BITS'(cmd.handle);
			mem_entry[wr_slot]  <= '{pts: cmd.pts, dts: cmd.dts, seq: seq_q, key: cmd.key};
		end
		if (rd_en) begin
			rd_handle_q <= mem_handle[rd_slot];
			rd_entry_q  <= mem_entry[rd_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			ticks_q  <= kapi_pkg::TICKS_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == kapi_pkg::REG_WINDOW) begin
				window_q <= cfg.data[15:0];
			end else if (cfg.index == kapi_pkg::REG_TICKS) begin
				ticks_q <= cfg.data;
			end
		end
	end

	// raise valid when a result is loaded, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_EVICT;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			seq_q       <= '0;
			newest_q    <= '0;
			since_q     <= '0;
			span_q      <= '0;
			status_q    <= kapi_pkg::STAT_OK;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q   <= '0;
						span_q  <= mul_p;
						since_q <= cmd.since;
						case (cmd.op)
							kapi_pkg::OP_ADD: begin
								if (refuse) begin
									status_q <= kapi_pkg::STAT_NONKEY;
									state_q  <= ST_RESP;
								end else begin
									status_q <= full ? kapi_pkg::STAT_DROPPED : kapi_pkg::STAT_OK;
									if (full) begin
										head_q <= head_inc;
									end else begin
										count_q <= count_q + CNT_W'(1);
									end
									seq_q    <= seq_q + 32'd1;
									newest_q <= cmd.pts;
									mode_q   <= MD_EVICT;
									if ((window_q != '0) && (full || (count_q != '0))) begin
										state_q <= ST_SCAN_RD;
									end else begin
										state_q <= ST_RESP;
									end
								end
							end
							kapi_pkg::OP_ALL: begin
								if (count_q == '0) begin
									status_q <= kapi_pkg::STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_EMIT_RD;
								end
							end
							kapi_pkg::OP_SINCE: begin
								mode_q  <= MD_SINCE;
								state_q <= ST_SCAN_RD;
							end
							kapi_pkg::OP_RECENT: begin
								if (count_q == '0) begin
									status_q <= kapi_pkg::STAT_EMPTY;
									state_q  <= ST_RESP;
								end else begin
									mode_q  <= MD_THRESH;
									state_q <= ST_SCAN_RD;
								end
							end
							kapi_pkg::OP_CLEAR: begin
								count_q  <= '0;
								head_q   <= '0;
								status_q <= kapi_pkg::STAT_CLEARED;
								state_q  <= ST_RESP;
							end
							default: begin
								status_q <= kapi_pkg::STAT_OK;
								state_q  <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (mode_q == MD_EVICT) begin
							state_q <= ST_DROP;
						end else begin
							status_q <= kapi_pkg::STAT_EMPTY;
							state_q  <= ST_RESP;
						end
					end else begin
						state_q <= ST_SCAN_CK;
					end
				end
				ST_SCAN_CK: begin
					case (mode_q)
						MD_EVICT: begin
							if (in_window) begin
								state_q <= ST_DROP;
							end else begin
								idx_q   <= idx_q + CNT_W'(1);
								state_q <= ST_SCAN_RD;
							end
						end
						MD_SINCE: begin
							if (ge_since) begin
								state_q <= ST_EMIT_RD;
							end else begin
								idx_q   <= idx_q + CNT_W'(1);
								state_q <= ST_SCAN_RD;
							end
						end
						MD_THRESH: begin
							state_q <= ST_SCAN_RD;
							if (in_window) begin
								mode_q <= MD_KEY;
							end else begin
								idx_q <= idx_q + CNT_W'(1);
							end
						end
						default: begin
							if (rd_entry_q.key) begin
								state_q <= ST_EMIT_RD;
							end else begin
								idx_q   <= idx_q + CNT_W'(1);
								state_q <= ST_SCAN_RD;
							end
						end
					endcase
				end
				ST_DROP: begin
					head_q  <= rd_slot;
					count_q <= count_q - idx_q;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						res_q   <= '{status: status_q, entry_valid: 1'b0, handle: '0, pts: '0,
						             dts: '0, seq: '0, key: 1'b0, last: 1'b1,
						             held: 7'(count_q)};
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					if (out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					res_q.status      <= kapi_pkg::STAT_OK;
					res_q.entry_valid <= 1'b1;
					res_q.handle      <= 32'(rd_handle_q);
					res_q.pts         <= rd_entry_q.pts;
					res_q.dts         <= rd_entry_q.dts;
					res_q.seq         <= rd_entry_q.seq;
					res_q.key         <= rd_entry_q.key;
					res_q.last        <= is_last;
					res_q.held        <= 7'(count_q);
					idx_q             <= idx_q + CNT_W'(1);
					state_q           <= is_last ? ST_IDLE : ST_EMIT_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/keyframe_aligned_prebuffer_index_unit.sv
// Keyframe-aligned prebuffer index: a ring of up to RING_DEPTH frame
// descriptors (handle, pts, dts, sequence, keyframe mark) held in one
// single-port memory with a registered read. Requests enter a two-deep queue
// and are executed one at a time by a sequencer, so the input keeps taking
// requests while a result waits on the output register. Each request yields
// one result, except reads, which stream one result per descriptor, oldest
// first, with last_of_run on the final one; a read with nothing to give
// yields one result with status empty. Every scan and every read shares the
// single memory read port, so entries are examined one at a time: an add
// checks 1 to RING_DEPTH entries when time eviction runs, and a read
// examines entries by its search and then emits its results. A full
// output register holds the sequencer until the result is taken.
// Configuration writes are taken at any time and must only be issued
// while the block is idle.
module keyframe_aligned_prebuffer_index_unit #(
	parameter int unsigned RING_DEPTH  = kapi_pkg::RING_DEPTH_DEF,
	parameter int unsigned HANDLE_BITS = kapi_pkg::HANDLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] payload_handle,
	input  logic [63:0] frame_pts,
	input  logic [63:0] frame_dts,
	input  logic        is_keyframe,
	input  logic [63:0] since_pts,
	input  logic [15:0] recent_seconds,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        entry_valid,
	output logic [31:0] out_handle,
	output logic [63:0] out_pts,
	output logic [63:0] out_dts,
	output logic [31:0] out_sequence,
	output logic        out_keyframe,
	output logic        last_of_run,
	output logic [6:0]  entries_held
);

	kapi_pkg::cmd_t    cmd;
	logic              cmd_valid;
	logic              cmd_pop;
	kapi_pkg::cfg_wr_t cfg;
	kapi_pkg::res_t    res;

	// registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// front: classify and queue requests
	kapi_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.payload_handle (payload_handle),
		.frame_pts      (frame_pts),
		.frame_dts      (frame_dts),
		.is_keyframe    (is_keyframe),
		.since_pts      (since_pts),
		.recent_seconds (recent_seconds),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	// back: ring memory, search sequencer and output register
	kapi_back #(
		.RING_DEPTH  (RING_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg       (cfg),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign status       = res.status;
	assign entry_valid  = res.entry_valid;
	assign out_handle   = res.handle;
	assign out_pts      = res.pts;
	assign out_dts      = res.dts;
	assign out_sequence = res.seq;
	assign out_keyframe = res.key;
	assign last_of_run  = res.last;
	assign entries_held = res.held;

endmodule

>>> rtl/kapi_checker.sv
module kapi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic        entry_valid,
	input logic [31:0] out_handle,
	input logic [63:0] out_pts,
	input logic        last_of_run,
	input logic [6:0]  entries_held
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pts) && $stable(last_of_run))
		else $error("stalled result changed");

	// streamed descriptors always report ok
	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> status == kapi_pkg::STAT_OK)
		else $error("descriptor with non-ok status");

	// a result without a descriptor ends its run and carries zeros
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> last_of_run && out_handle == 32'd0 && out_pts == 64'd0)
		else $error("bad single result");

	// occupancy never exceeds the ring
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entries_held <= 7'd64)
		else $error("occupancy out of range");

endmodule

bind keyframe_aligned_prebuffer_index_unit kapi_checker u_kapi_checker (.*);
